[design/xmb_pkg.sv]
package xmb_pkg;

  localparam int SHORT_BLOCK_DEF = 128;
  localparam int LONG_BLOCK_DEF  = 1024;
  localparam int IDX_W = 10;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TMO   = 2'd2;

  localparam logic [7:0] C_SOH   = 8'h01;
  localparam logic [7:0] C_STX   = 8'h02;
  localparam logic [7:0] C_EOT   = 8'h04;
  localparam logic [7:0] C_ACK   = 8'h06;
  localparam logic [7:0] C_NAK   = 8'h15;
  localparam logic [7:0] C_CAN   = 8'h18;
  localparam logic [7:0] C_INITC = 8'h43;

  localparam logic [1:0] VERD_NONE   = 2'd0;
  localparam logic [1:0] VERD_COMMIT = 2'd1;
  localparam logic [1:0] VERD_DUP    = 2'd2;
  localparam logic [1:0] VERD_REJECT = 2'd3;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_INIT_FAIL = 3'd3;
  localparam logic [2:0] ST_INIT_CAN  = 3'd4;
  localparam logic [2:0] ST_SEND_CAN  = 3'd5;
  localparam logic [2:0] ST_CARRIER   = 3'd6;

  localparam logic [0:0] REG_CRC_MODE  = 1'd0;
  localparam logic [0:0] REG_MAX_TRIES = 1'd1;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic       start;
    logic       byte_ok;
    logic       tmo;
    logic       is_soh;
    logic       is_stx;
    logic       is_eot;
    logic       is_can;
    logic       carrier;
    logic [7:0] rx_byte;
  } xmb_item_t;

  localparam int ITEM_W = $bits(xmb_item_t);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

[design/xmb_front.sv]
module xmb_front
  import xmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  input  logic       carrier,
  output logic       q_valid,
  input  logic       q_ready,
  output xmb_item_t  q_item
);

  xmb_item_t item;
  xmb_item_t mem [2];
  logic      wptr, rptr;
  logic [1:0] count;

  always_comb begin
    item = '0;
    item.start   = (func == FUNC_START);
    item.byte_ok = (func == FUNC_BYTE);
    item.tmo     = (func == FUNC_TMO);
    item.is_soh  = (rx_byte == C_SOH);
    item.is_stx  = (rx_byte == C_STX);
    item.is_eot  = (rx_byte == C_EOT);
    item.is_can  = (rx_byte == C_CAN);
    item.carrier = carrier;
    item.rx_byte = rx_byte;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];

  logic push, pop;
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/xmb_back.sv]
module xmb_back
  import xmb_pkg::*;
#(
  parameter int SHORT_BLOCK = SHORT_BLOCK_DEF,
  parameter int LONG_BLOCK  = LONG_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  xmb_item_t  q_item,
  input  logic       crc_mode,
  input  logic [3:0] max_init_tries,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [31:0] out_data
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_INIT = 4'd1;
  localparam logic [3:0] PH_NUM  = 4'd2;
  localparam logic [3:0] PH_INV  = 4'd3;
  localparam logic [3:0] PH_DATA = 4'd4;
  localparam logic [3:0] PH_CHK1 = 4'd5;
  localparam logic [3:0] PH_CHK2 = 4'd6;
  localparam logic [3:0] PH_HDR  = 4'd7;
  localparam logic [3:0] PH_CAN2 = 4'd8;

  localparam logic [IDX_W-1:0] SHORT_LAST = IDX_W'(SHORT_BLOCK - 1);
  localparam logic [IDX_W-1:0] LONG_LAST  = IDX_W'(LONG_BLOCK - 1);

  logic [3:0]       phase, phase_next;
  logic [3:0]       init_tries, init_tries_next;
  logic [7:0]       expected_number, expected_number_next;
  logic [7:0]       got_number, got_number_next;
  logic [7:0]       got_inverse, got_inverse_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic             long_block, long_block_next;
  logic [15:0]      crc_accum, crc_accum_next;
  logic [7:0]       sum_accum, sum_accum_next;
  logic [15:0]      got_check, got_check_next;

  logic       txv, dv;
  logic [7:0] txb, db;
  logic [1:0] verdict;
  logic [2:0] status;
  logic       evaluate, ok;
  logic [7:0] b;
  logic       step;

  assign q_ready = !out_valid || out_ready;
  assign step = q_valid && q_ready;
  assign b = q_item.rx_byte;

  always_comb begin
    phase_next = phase;
    init_tries_next = init_tries;
    expected_number_next = expected_number;
    got_number_next = got_number;
    got_inverse_next = got_inverse;
    byte_index_next = byte_index;
    long_block_next = long_block;
    crc_accum_next = crc_accum;
    sum_accum_next = sum_accum;
    got_check_next = got_check;
    txv = 1'b0; txb = 8'h00; dv = 1'b0; db = 8'h00;
    verdict = VERD_NONE; status = ST_NONE;
    evaluate = 1'b0; ok = 1'b0;
    if (q_item.start) begin
      expected_number_next = 8'd1;
      init_tries_next = 4'd1;
      phase_next = PH_INIT;
      txv = 1'b1;
      txb = crc_mode ? C_INITC : C_NAK;
    end else if (q_item.byte_ok || q_item.tmo) begin
      unique case (phase)
        PH_INIT: begin
          if (q_item.byte_ok && (q_item.is_soh || q_item.is_stx)) begin
            long_block_next = q_item.is_stx;
            byte_index_next = '0; crc_accum_next = '0;
            sum_accum_next = '0; got_check_next = '0;
            phase_next = PH_NUM;
          end else if (q_item.byte_ok && q_item.is_eot) begin
            status = ST_EMPTY; phase_next = PH_IDLE;
          end else if (q_item.byte_ok && q_item.is_can) begin
            status = ST_INIT_CAN; phase_next = PH_IDLE;
          end else if (init_tries >= max_init_tries) begin
            status = ST_INIT_FAIL; phase_next = PH_IDLE;
          end else begin
            init_tries_next = init_tries + 4'd1;
            txv = 1'b1;
            txb = crc_mode ? C_INITC : C_NAK;
          end
        end
        PH_NUM, PH_INV, PH_DATA, PH_CHK1, PH_CHK2: begin
          if (q_item.tmo) begin
            txv = 1'b1; txb = C_NAK; verdict = VERD_REJECT; phase_next = PH_HDR;
          end else if (phase == PH_NUM) begin
            got_number_next = b; phase_next = PH_INV;
          end else if (phase == PH_INV) begin
            got_inverse_next = b; phase_next = PH_DATA;
          end else if (phase == PH_DATA) begin
            dv = 1'b1; db = b;
            crc_accum_next = crc_byte(crc_accum, b);
            sum_accum_next = sum_accum + b;
            if (byte_index == (long_block ? LONG_LAST : SHORT_LAST)) begin
              byte_index_next = '0; phase_next = PH_CHK1;
            end else begin
              byte_index_next = byte_index + 1'b1;
            end
          end else if (phase == PH_CHK1) begin
            if (crc_mode) begin
              got_check_next = {b, 8'h00}; phase_next = PH_CHK2;
            end else begin
              got_check_next = {8'h00, b}; evaluate = 1'b1;
            end
          end else begin
            got_check_next = {got_check[15:8], b}; evaluate = 1'b1;
          end
        end
        PH_HDR: begin
          if (q_item.tmo) begin
            txv = 1'b1; txb = C_NAK;
          end else if (q_item.is_eot) begin
            txv = 1'b1; txb = C_ACK; status = ST_DONE; phase_next = PH_IDLE;
          end else if (q_item.is_can) begin
            phase_next = PH_CAN2;
          end else if (q_item.is_soh || q_item.is_stx) begin
            if (!q_item.carrier) begin
              status = ST_CARRIER; phase_next = PH_IDLE;
            end else begin
              long_block_next = q_item.is_stx;
              byte_index_next = '0; crc_accum_next = '0;
              sum_accum_next = '0; got_check_next = '0;
              phase_next = PH_NUM;
            end
          end
        end
        PH_CAN2: begin
          if (q_item.byte_ok && q_item.is_can) begin
            status = ST_SEND_CAN; phase_next = PH_IDLE;
          end else begin
            phase_next = PH_HDR;
          end
        end
        default: ;
      endcase
    end
    if (evaluate) begin
      ok = crc_mode ? (got_check_next == crc_accum) : (got_check_next[7:0] == sum_accum
                                                       && got_check_next[15:8] == 8'h00);
      if ((got_number ^ got_inverse) != 8'hFF) ok = 1'b0;
      txv = 1'b1;
      if (got_number == expected_number - 8'd1) begin
        txb = C_ACK; verdict = VERD_DUP;
      end else if (ok && got_number == expected_number) begin
        txb = C_ACK; verdict = VERD_COMMIT;
        expected_number_next = expected_number + 8'd1;
      end else begin
        txb = C_NAK; verdict = VERD_REJECT;
      end
      phase_next = PH_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      init_tries <= '0;
      expected_number <= 8'd1;
      got_number <= '0;
      got_inverse <= '0;
      byte_index <= '0;
      long_block <= 1'b0;
      crc_accum <= '0;
      sum_accum <= '0;
      got_check <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase <= phase_next;
        init_tries <= init_tries_next;
        expected_number <= expected_number_next;
        got_number <= got_number_next;
        got_inverse <= got_inverse_next;
        byte_index <= byte_index_next;
        long_block <= long_block_next;
        crc_accum <= crc_accum_next;
        sum_accum <= sum_accum_next;
        got_check <= got_check_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {1'd0, expected_number_next, status, verdict, db, dv, txb, txv};
    end
  end

endmodule

[design/xmodem_block_receiver.sv]
// Channel  Direction  Payload
// s_axis   in         tdata: func[1:0], rx_byte[9:2], carrier[10]
// m_axis   out        tdata: tx_valid, tx_byte, data_valid, data_byte, verdict, status, number
// apb      in         reg 0 crc_mode at 0x0, reg 1 max_init_tries at 0x4
// One word is accepted per cycle while tready is high; its result passes the queue and then the output register.
// The front holds a two-entry queue; the back keeps one output register.
// Reset is synchronous, clears the queue and the receive state, and sets crc_mode to 1 and max_init_tries to 10.
// A stalled output stops the back, and the queue then fills and drops tready.
module xmodem_block_receiver
  import xmb_pkg::*;
#(
  parameter int SHORT_BLOCK = SHORT_BLOCK_DEF,
  parameter int LONG_BLOCK  = LONG_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // func[1:0], rx_byte[9:2], carrier[10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_valid[0], tx_byte[8:1], data_valid[9], data_byte[17:10], block_verdict[19:18],
  // status[22:20], next_block_number[30:23]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       crc_mode;
  logic [3:0] max_init_tries;
  logic       q_valid, q_ready;
  xmb_item_t  q_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= 1'b1;
      max_init_tries <= 4'd10;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CRC_MODE) crc_mode <= pwdata[0];
      else max_init_tries <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_TRIES) prdata = {28'd0, max_init_tries};
    else prdata = {31'd0, crc_mode};
  end

  xmb_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tdata[1:0]), .rx_byte(s_axis_tdata[9:2]), .carrier(s_axis_tdata[10]),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  xmb_back #(.SHORT_BLOCK(SHORT_BLOCK), .LONG_BLOCK(LONG_BLOCK)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .crc_mode(crc_mode), .max_init_tries(max_init_tries),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

[test/tb_xmodem_block_receiver.sv]
module tb_xmodem_block_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import xmb_pkg::*;

  typedef enum logic [3:0] {
    RX_IDLE, RX_INIT, RX_NUM, RX_INV, RX_DATA, RX_CHK1, RX_CHK2, RX_HDR, RX_CAN2
  } rx_phase_t;

  localparam logic [2:0] ADDR_CRC_MODE  = 3'd4 * REG_CRC_MODE;
  localparam logic [2:0] ADDR_MAX_TRIES = 3'd4 * REG_MAX_TRIES;
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;

  // Packed in the order of m_axis_tdata, highest field first.
  typedef struct packed {
    logic [7:0] next_num;
    logic [2:0] status;
    logic [1:0] verdict;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } rx_result_t;

  class receiver_scoreboard;
    bit         crc_on;
    bit [3:0]   tries_limit;
    rx_phase_t  ph;
    bit [3:0]   tries;
    bit [7:0]   next_num;
    bit [7:0]   blk_num;
    bit [7:0]   blk_inv;
    bit [9:0]   idx;
    bit         is_long;
    bit [15:0]  crc_acc;
    bit [7:0]   sum_acc;
    bit [15:0]  chk;
    rx_result_t pending_results[$];
    int         errors;

    function new();
      crc_on = 1'b1;
      tries_limit = 4'd10;
      ph = RX_IDLE;
      tries = '0;
      next_num = 8'd1;
      errors = 0;
    endfunction

    static function bit [15:0] crc16(bit [15:0] crc, bit [7:0] b);
      bit [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
    endfunction

    function void open_block(bit [7:0] hdr);
      is_long = (hdr == C_STX);
      idx = '0;
      crc_acc = '0;
      sum_acc = '0;
      chk = '0;
      ph = RX_NUM;
    endfunction

    function void note_input(bit [1:0] func, bit [7:0] b, bit car);
      rx_result_t r;
      bit tmo;
      bit judge;
      bit ok;
      int size;
      r = '0;
      judge = 1'b0;
      tmo = (func == FUNC_TMO);
      size = is_long ? LONG_BLOCK_DEF : SHORT_BLOCK_DEF;
      if (func == FUNC_START) begin
        next_num = 8'd1;
        tries = 4'd1;
        ph = RX_INIT;
        r.tx_valid = 1'b1;
        r.tx_byte = crc_on ? C_INITC : C_NAK;
      end else if (func == FUNC_BYTE || tmo) begin
        case (ph)
          RX_INIT: begin
            if (!tmo && (b == C_SOH || b == C_STX)) open_block(b);
            else if (!tmo && b == C_EOT) begin
              r.status = ST_EMPTY; ph = RX_IDLE;
            end else if (!tmo && b == C_CAN) begin
              r.status = ST_INIT_CAN; ph = RX_IDLE;
            end else if (tries >= tries_limit) begin
              r.status = ST_INIT_FAIL; ph = RX_IDLE;
            end else begin
              tries++;
              r.tx_valid = 1'b1;
              r.tx_byte = crc_on ? C_INITC : C_NAK;
            end
          end
          RX_NUM, RX_INV, RX_DATA, RX_CHK1, RX_CHK2: begin
            if (tmo) begin
              r.tx_valid = 1'b1; r.tx_byte = C_NAK; r.verdict = VERD_REJECT; ph = RX_HDR;
            end else if (ph == RX_NUM) begin
              blk_num = b; ph = RX_INV;
            end else if (ph == RX_INV) begin
              blk_inv = b; ph = RX_DATA;
            end else if (ph == RX_DATA) begin
              r.data_valid = 1'b1;
              r.data_byte = b;
              crc_acc = crc16(crc_acc, b);
              sum_acc += b;
              if (idx + 1 >= size) begin
                idx = '0; ph = RX_CHK1;
              end else idx++;
            end else if (ph == RX_CHK1) begin
              if (crc_on) begin
                chk = {b, 8'h00}; ph = RX_CHK2;
              end else begin
                chk = {8'h00, b}; judge = 1'b1;
              end
            end else begin
              chk[7:0] = b; judge = 1'b1;
            end
          end
          RX_HDR: begin
            if (tmo) begin
              r.tx_valid = 1'b1; r.tx_byte = C_NAK;
            end else if (b == C_EOT) begin
              r.tx_valid = 1'b1; r.tx_byte = C_ACK; r.status = ST_DONE; ph = RX_IDLE;
            end else if (b == C_CAN) ph = RX_CAN2;
            else if (b == C_SOH || b == C_STX) begin
              if (!car) begin
                r.status = ST_CARRIER; ph = RX_IDLE;
              end else open_block(b);
            end
          end
          RX_CAN2: begin
            if (!tmo && b == C_CAN) begin
              r.status = ST_SEND_CAN; ph = RX_IDLE;
            end else ph = RX_HDR;
          end
          default: ;
        endcase
      end
      if (judge) begin
        ok = crc_on ? (chk == crc_acc) : (chk[7:0] == sum_acc && chk[15:8] == 8'h00);
        if ((blk_num ^ blk_inv) != 8'hFF) ok = 1'b0;
        r.tx_valid = 1'b1;
        if (blk_num == next_num - 8'd1) begin
          r.tx_byte = C_ACK; r.verdict = VERD_DUP;
        end else if (ok && blk_num == next_num) begin
          r.tx_byte = C_ACK; r.verdict = VERD_COMMIT;
          next_num++;
        end else begin
          r.tx_byte = C_NAK; r.verdict = VERD_REJECT;
        end
        ph = RX_HDR;
      end
      r.next_num = next_num;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] word);
      rx_result_t got;
      rx_result_t want;
      got = word[30:0];
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word %h", word));
        return;
      end
      want = pending_results.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.data_valid !== want.data_valid)
        report($sformatf("data_valid %b, want %b", got.data_valid, want.data_valid));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
      if (got.verdict !== want.verdict)
        report($sformatf("block_verdict %0d, want %0d", got.verdict, want.verdict));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.next_num !== want.next_num)
        report($sformatf("next_block_number %h, want %h", got.next_num, want.next_num));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xmodem_block_receiver DUT (.*);

  receiver_scoreboard sb = new();
  int burst_left = 0;
  int words_sent = 0;
  int stall_left = 0;
  int stall_kind = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_kind)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_left % 4 != 0);
      default: m_axis_tready <= (stall_left % 8 < 2);
    endcase
  end

  task send(logic [1:0] func, logic [7:0] b, logic car);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, car, b, func};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(func, b, car);
    burst_left--;
    words_sent++;
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task reg_write(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_CRC_MODE) sb.crc_on = value[0];
    else sb.tries_limit = value[3:0];
  endtask

  task configure(bit crc, bit [3:0] limit);
    drain();
    reg_write(ADDR_CRC_MODE, {31'd0, crc});
    reg_write(ADDR_MAX_TRIES, {28'd0, limit});
  endtask

  task send_byte(logic [7:0] b);
    send(FUNC_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == C_SOH || b == C_STX || b == C_EOT || b == C_CAN);
    return b;
  endfunction

  task send_block(bit long_blk);
    logic [7:0] num;
    logic [7:0] b;
    logic [15:0] crc;
    logic [7:0] sum;
    int size;
    int kind;
    size = long_blk ? LONG_BLOCK_DEF : SHORT_BLOCK_DEF;
    kind = $urandom_range(0, 9);
    send(FUNC_BYTE, long_blk ? C_STX : C_SOH, kind != 9 || $urandom_range(0, 3) != 0);
    if (sb.ph == RX_IDLE) return;
    if (kind == 7) num = sb.next_num - 8'd1;
    else if (kind == 8) num = 8'($urandom_range(0, 255));
    else num = sb.next_num;
    send_byte(num);
    send_byte((kind == 6) ? ~num ^ (8'd1 << $urandom_range(0, 7)) : ~num);
    crc = '0;
    sum = '0;
    for (int i = 0; i < size; i++) begin
      if (kind == 5 && i == size / 2) begin
        send(FUNC_TMO, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        return;
      end
      b = 8'($urandom_range(0, 255));
      crc = receiver_scoreboard::crc16(crc, b);
      sum += b;
      send_byte(b);
    end
    if (kind == 4) crc ^= 16'h0001 << $urandom_range(0, 15);
    if (kind == 4) sum ^= 8'h01 << $urandom_range(0, 7);
    if (sb.crc_on) begin
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
    end else send_byte(sum);
  endtask

  task run_transfer(bit with_long);
    int noise;
    int blocks;
    send(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    noise = ($urandom_range(0, 4) == 0) ? sb.tries_limit + 1 : $urandom_range(0, 2);
    for (int i = 0; i < noise && sb.ph == RX_INIT; i++) begin
      if ($urandom_range(0, 1))
        send(FUNC_TMO, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else send_byte(stray_byte());
    end
    if (sb.ph != RX_INIT) return;
    blocks = $urandom_range(1, 3);
    for (int k = 0; k < blocks && sb.ph != RX_IDLE; k++) begin
      send_block(with_long && k == 0);
      if (sb.ph == RX_IDLE) return;
      case ($urandom_range(0, 5))
        0: send_byte(stray_byte());
        1: send(FUNC_TMO, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        2: begin
          send_byte(C_CAN);
          send_byte(stray_byte());
        end
        default: ;
      endcase
    end
    if (sb.ph == RX_IDLE) return;
    case ($urandom_range(0, 5))
      0: begin
        send_byte(C_CAN);
        send_byte(C_CAN);
      end
      1: ;
      default: send_byte(C_EOT);
    endcase
  endtask

  initial begin
    int t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FUNC_BYTE, 8'hFF, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b0);
    send(FUNC_UNUSED, 8'hA5, 1'b1);
    send(FUNC_START, 8'h00, 1'b1);
    send(FUNC_BYTE, C_EOT, 1'b1);
    send(FUNC_START, 8'hFF, 1'b0);
    send(FUNC_BYTE, C_CAN, 1'b0);
    send(FUNC_START, 8'h00, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b1);
    send(FUNC_BYTE, 8'h55, 1'b1);
    send(FUNC_BYTE, C_SOH, 1'b0);
    send(FUNC_TMO, 8'h00, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b1);
    send(FUNC_BYTE, 8'h7E, 1'b1);
    send(FUNC_BYTE, C_CAN, 1'b1);
    send(FUNC_BYTE, 8'h00, 1'b1);
    send(FUNC_BYTE, C_CAN, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b1);
    send(FUNC_BYTE, C_CAN, 1'b1);
    send(FUNC_BYTE, C_CAN, 1'b1);
    send(FUNC_START, 8'h00, 1'b1);
    send(FUNC_BYTE, C_STX, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b1);
    send(FUNC_BYTE, C_STX, 1'b0);
    configure(1'b0, 4'd1);
    send(FUNC_START, 8'h00, 1'b1);
    send(FUNC_TMO, 8'h00, 1'b1);

    t = 0;
    while (words_sent < 850) begin
      if (t % 3 == 0) begin
        case (t / 3 % 4)
          0: configure(1'b1, 4'd15);
          1: configure(1'b0, 4'd1);
          default: configure(1'($urandom_range(0, 1)), 4'($urandom_range(1, 15)));
        endcase
      end
      run_transfer(t == 2);
      if (t == 4) drain();
      t++;
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
